[sv/assert_macros.svh]
// Assertion macros used by the checker file.
// Clocked on clock; the first form is masked while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked out of reset only
`define TCGS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// property checked at every edge, reset included
`define TCGS_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

[sv/tcgs_pkg.sv]
// Shared types and constants for the span shader.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package tcgs_pkg;

   // sizing
   localparam int MAX_SPAN    = 64;
   localparam int COORD_BITS  = 12;
   localparam int SPAN_X_W    = 12;
   localparam int SPAN_LEN_W  = 7;
   localparam int SPAN_CNT_W  = $clog2(MAX_SPAN + 1);
   localparam int CRD_W       = (COORD_BITS < SPAN_X_W) ? COORD_BITS : SPAN_X_W;
   // coefficient times (2c+1)
   localparam int PROD_W      = 32 + CRD_W + 2;
   // running u/v: start value plus up to MAX_SPAN steps of 2*coefficient
   localparam int UV_GROW_W   = 33 + SPAN_CNT_W;
   localparam int UV_W        = ((PROD_W > UV_GROW_W) ? PROD_W : UV_GROW_W) + 2;

   // register indexes
   localparam int CSR_IDX_W   = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_ROW_U     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_ROW_V     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_OFFSETS   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_COLOR    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DELTA_U_COLOR = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DELTA_V_COLOR = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_GLOBAL_ALPHA  = 3'd6;
   localparam logic [15:0] GLOBAL_ALPHA_RESET = 16'h8000;

   typedef struct packed {
      logic [SPAN_X_W-1:0]   span_x;
      logic [SPAN_X_W-1:0]   span_y;
      logic [SPAN_LEN_W-1:0] span_length;
   } req_type;

   typedef struct packed {
      logic [7:0] alpha_out;
      logic [7:0] red_out;
      logic [7:0] green_out;
      logic [7:0] blue_out;
      logic       last_pixel;
   } rsp_type;

   typedef struct packed {
      logic [63:0] inv_row_u;
      logic [63:0] inv_row_v;
      logic [63:0] inv_offsets;
      logic [63:0] base_color;
      logic [63:0] delta_u_color;
      logic [63:0] delta_v_color;
      logic [15:0] global_alpha;
   } cfg_type;

   // controller to datapath
   typedef struct packed {
      logic capture;  // latch span start
      logic mul;      // form coefficient products
      logic load;     // sum products into u/v
      logic issue;    // launch one pixel
      logic last;     // launched pixel closes the span
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic advance;  // pipeline moves this cycle
   } sts_type;

endpackage

[sv/tcgs_csr.sv]
// Configuration register bank for the span shader.
// Depends on tcgs_pkg for the register indexes and cfg_type.
`timescale 1ns / 1ps

module tcgs_csr import tcgs_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [63:0]          csr_wdata,
   output cfg_type              cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_INV_ROW_U:     cfg_in.inv_row_u     = csr_wdata;
            CSR_INV_ROW_V:     cfg_in.inv_row_v     = csr_wdata;
            CSR_INV_OFFSETS:   cfg_in.inv_offsets   = csr_wdata;
            CSR_BASE_COLOR:    cfg_in.base_color    = csr_wdata;
            CSR_DELTA_U_COLOR: cfg_in.delta_u_color = csr_wdata;
            CSR_DELTA_V_COLOR: cfg_in.delta_v_color = csr_wdata;
            CSR_GLOBAL_ALPHA:  cfg_in.global_alpha  = csr_wdata[15:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff              <= '0;
         cfg_ff.global_alpha <= GLOBAL_ALPHA_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[sv/tcgs_ctrl.sv]
// Span sequencer: takes a request, runs the u/v setup and launches one
// pixel per advancing cycle. Depends on tcgs_pkg.
`timescale 1ns / 1ps

module tcgs_ctrl import tcgs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic [SPAN_LEN_W-1:0] req_length,
   output logic                  req_stall,
   output cmd_type               cmd,
   input  sts_type               sts
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MUL  = 2'd1;
   localparam logic [1:0] ST_LOAD = 2'd2;
   localparam logic [1:0] ST_RUN  = 2'd3;

   localparam int CMP_W = (SPAN_CNT_W > SPAN_LEN_W) ? SPAN_CNT_W : SPAN_LEN_W;

   logic [1:0]            state_ff, state_in;
   logic [SPAN_CNT_W-1:0] count_ff, count_in;
   logic [SPAN_CNT_W-1:0] len_sat;
   logic [CMP_W-1:0]      len_ext;
   logic                  accept;

   // lengths above the span limit are clipped to it
   always_comb begin
      len_ext = CMP_W'(req_length);
      if (len_ext > CMP_W'(MAX_SPAN)) begin
         len_sat = SPAN_CNT_W'(MAX_SPAN);
      end else begin
         len_sat = SPAN_CNT_W'(len_ext);
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && (state_ff == ST_IDLE);

   always_comb begin
      cmd.capture = accept;
      cmd.mul     = (state_ff == ST_MUL);
      cmd.load    = (state_ff == ST_LOAD);
      cmd.issue   = (state_ff == ST_RUN) && sts.advance;
      cmd.last    = (count_ff == SPAN_CNT_W'(1));
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (len_sat != '0)) begin
               state_in = ST_MUL;
               count_in = len_sat;
            end
         end
         ST_MUL:  state_in = ST_LOAD;
         ST_LOAD: state_in = ST_RUN;
         ST_RUN: begin
            if (cmd.issue) begin
               count_in = count_ff - SPAN_CNT_W'(1);
               if (cmd.last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

endmodule

[sv/tcgs_dpath.sv]
// Shading datapath: u/v setup and stepping, then a six-stage pixel pipe
// (clamp, products, channel sums, alpha, premultiply, output). Depends on tcgs_pkg.
`timescale 1ns / 1ps

module tcgs_dpath import tcgs_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  req_type req_data,
   input  cmd_type cmd,
   output sts_type sts,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int UVX_W = (UV_W > 48) ? UV_W : 48;
   localparam logic signed [UVX_W-1:0] UV_HI = {{(UVX_W-46){1'b0}}, {46{1'b1}}};
   localparam logic signed [UVX_W-1:0] UV_LO = -UV_HI;
   localparam logic signed [17:0] Q_MAX = 18'sh1FFFF;
   localparam logic signed [17:0] Q_MIN = -18'sh20000;

   // clamp/floor of a Q.30 unit value to 0..255
   function automatic logic [7:0] u8_q30(input logic signed [34:0] v);
      logic [37:0] t;
      t = {v[29:0], 8'b0} - {8'b0, v[29:0]};
      priority if (v[34] || (v == '0)) return 8'd0;
      else if (|v[33:30])               return 8'd255;
      else                              return t[37:30];
   endfunction

   // same for Q.45
   function automatic logic [7:0] u8_q45(input logic signed [52:0] v);
      logic [52:0] t;
      t = {v[44:0], 8'b0} - {8'b0, v[44:0]};
      priority if (v[52] || (v == '0)) return 8'd0;
      else if (|v[51:45])               return 8'd255;
      else                              return t[52:45];
   endfunction

   logic advance;

   // setup
   logic [CRD_W-1:0]         x_ff, y_ff;
   logic signed [CRD_W+1:0]  x2, y2;
   logic signed [31:0]       su, ku, sv, kv, tu, tv;
   logic signed [32:0]       su2, sv2, tu2, tv2;
   logic signed [PROD_W-1:0] pux_ff, puy_ff, pvx_ff, pvy_ff;
   logic signed [PROD_W-1:0] pux_in, puy_in, pvx_in, pvy_in;
   logic signed [UV_W-1:0]   u_ff, v_ff, u_in, v_in;

   // stage a: clamped u/v
   logic                     a_vld_ff, a_last_ff;
   logic signed [UVX_W-1:0]  u_x, v_x;
   logic signed [46:0]       uc_ff, vcl_ff, uc_in, vcl_in;

   // stage b: colour products
   logic                     b_vld_ff, b_last_ff;
   logic signed [62:0]       pu_ff [4];
   logic signed [62:0]       pv_ff [4];
   logic signed [62:0]       pu_in [4];
   logic signed [62:0]       pv_in [4];

   // stage c: channel values, Q.15 saturated
   logic                     c_vld_ff, c_last_ff;
   logic signed [17:0]       q_ff [4];
   logic signed [17:0]       q_in [4];

   // stage d: scaled alpha
   logic                     d_vld_ff, d_last_ff;
   logic signed [16:0]       ga;
   logic signed [34:0]       pa_ff, pa_in;
   logic signed [17:0]       qd_ff [3];

   // stage e: premultiplied colour
   logic                     e_vld_ff, e_last_ff;
   logic signed [34:0]       pae_ff;
   logic signed [52:0]       pe_ff [3];
   logic signed [52:0]       pe_in [3];

   // output register
   logic                     rsp_valid_ff;
   rsp_type                  rsp_ff, rsp_in;

   // the whole pipe holds while a finished pixel waits
   assign advance     = !rsp_valid_ff || !rsp_stall;
   assign sts.advance = advance;

   assign su  = $signed(cfg.inv_row_u[31:0]);
   assign ku  = $signed(cfg.inv_row_u[63:32]);
   assign sv  = $signed(cfg.inv_row_v[31:0]);
   assign kv  = $signed(cfg.inv_row_v[63:32]);
   assign tu  = $signed(cfg.inv_offsets[31:0]);
   assign tv  = $signed(cfg.inv_offsets[63:32]);
   assign su2 = $signed({su, 1'b0});
   assign sv2 = $signed({sv, 1'b0});
   assign tu2 = $signed({tu, 1'b0});
   assign tv2 = $signed({tv, 1'b0});

   // pixel centre doubled: 2c+1
   assign x2 = $signed({1'b0, x_ff, 1'b1});
   assign y2 = $signed({1'b0, y_ff, 1'b1});

   assign pux_in = su * x2;
   assign puy_in = ku * y2;
   assign pvx_in = sv * x2;
   assign pvy_in = kv * y2;

   always_comb begin
      priority if (cmd.load) begin
         u_in = UV_W'(pux_ff) + UV_W'(puy_ff) + UV_W'(tu2);
         v_in = UV_W'(pvx_ff) + UV_W'(pvy_ff) + UV_W'(tv2);
      end else if (cmd.issue) begin
         u_in = u_ff + UV_W'(su2);
         v_in = v_ff + UV_W'(sv2);
      end else begin
         u_in = u_ff;
         v_in = v_ff;
      end
   end

   always_comb begin
      u_x = UVX_W'(u_ff);
      v_x = UVX_W'(v_ff);
      priority if (u_x > UV_HI) uc_in = UV_HI[46:0];
      else if (u_x < UV_LO)     uc_in = UV_LO[46:0];
      else                      uc_in = u_x[46:0];
      priority if (v_x > UV_HI) vcl_in = UV_HI[46:0];
      else if (v_x < UV_LO)     vcl_in = UV_LO[46:0];
      else                      vcl_in = v_x[46:0];
   end

   // channel 0 is alpha in the top 16 bits, then r, g, b
   always_comb begin
      for (int ch = 0; ch < 4; ch++) begin
         pu_in[ch] = uc_ff  * $signed(cfg.delta_u_color[63-16*ch -: 16]);
         pv_in[ch] = vcl_ff * $signed(cfg.delta_v_color[63-16*ch -: 16]);
      end
   end

   always_comb begin
      logic signed [63:0] c_sum;
      for (int ch = 0; ch < 4; ch++) begin
         c_sum = 64'(pu_ff[ch]) + 64'(pv_ff[ch])
               + $signed({31'b0, cfg.base_color[63-16*ch -: 16], 17'b0});
         // floor to Q.15 is the arithmetic shift; saturate if it leaves 18 bits
         if ((&c_sum[63:34]) || !(|c_sum[63:34])) begin
            q_in[ch] = c_sum[34:17];
         end else begin
            q_in[ch] = c_sum[63] ? Q_MIN : Q_MAX;
         end
      end
   end

   assign ga    = $signed({1'b0, cfg.global_alpha});
   assign pa_in = q_ff[0] * ga;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pe_in[i] = qd_ff[i] * pa_ff;
      end
   end

   always_comb begin
      rsp_in.alpha_out  = u8_q30(pae_ff);
      rsp_in.red_out    = u8_q45(pe_ff[0]);
      rsp_in.green_out  = u8_q45(pe_ff[1]);
      rsp_in.blue_out   = u8_q45(pe_ff[2]);
      rsp_in.last_pixel = e_last_ff;
   end

   // setup registers and payload, no reset
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         x_ff <= req_data.span_x[CRD_W-1:0];
         y_ff <= req_data.span_y[CRD_W-1:0];
      end
      if (cmd.mul) begin
         pux_ff <= pux_in;
         puy_ff <= puy_in;
         pvx_ff <= pvx_in;
         pvy_ff <= pvy_in;
      end
      u_ff <= u_in;
      v_ff <= v_in;
      if (advance) begin
         a_last_ff <= cmd.last;
         uc_ff     <= uc_in;
         vcl_ff    <= vcl_in;
         b_last_ff <= a_last_ff;
         pu_ff     <= pu_in;
         pv_ff     <= pv_in;
         c_last_ff <= b_last_ff;
         q_ff      <= q_in;
         d_last_ff <= c_last_ff;
         pa_ff     <= pa_in;
         qd_ff[0]  <= q_ff[1];
         qd_ff[1]  <= q_ff[2];
         qd_ff[2]  <= q_ff[3];
         e_last_ff <= d_last_ff;
         pae_ff    <= pa_ff;
         pe_ff     <= pe_in;
         rsp_ff    <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff     <= 1'b0;
         b_vld_ff     <= 1'b0;
         c_vld_ff     <= 1'b0;
         d_vld_ff     <= 1'b0;
         e_vld_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         a_vld_ff     <= cmd.issue;
         b_vld_ff     <= a_vld_ff;
         c_vld_ff     <= b_vld_ff;
         d_vld_ff     <= c_vld_ff;
         e_vld_ff     <= d_vld_ff;
         rsp_valid_ff <= e_vld_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[sv/triangle_color_gradient_span.sv]
// Barycentric Gouraud span shader. One request names a start pixel and a
// length of 1 to 64 pixels (longer lengths are clipped, zero gives nothing);
// the block returns one shaded, premultiplied ARGB8 pixel per position,
// the final one flagged with last_pixel. After the accept, a span holds the
// request side through the MUL and LOAD states, which form the start u/v from
// the coefficient products, and the RUN state, which launches one pixel per
// advancing cycle from the stepping u/v registers. The next request is taken
// while launched pixels drain. A stalled result holds the whole pixel pipe.
// Registers must be written only between spans; the block does not enforce it.
// Depends on tcgs_pkg, tcgs_csr, tcgs_ctrl and tcgs_dpath.
`timescale 1ns / 1ps

module triangle_color_gradient_span import tcgs_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [63:0]          csr_wdata
);

   cfg_type cfg;
   cmd_type cmd;
   sts_type sts;

   tcgs_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   tcgs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_length (req_data.span_length),
      .req_stall  (req_stall),
      .cmd        (cmd),
      .sts        (sts)
   );

   tcgs_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

[sv/tcgs_checker.sv]
// Port-level checks for the span shader, bound to the top level.
// Depends on tcgs_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tcgs_checker import tcgs_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   logic span_go;
   logic rsp_held;

   assign span_go  = req_valid && !req_stall && (req_data.span_length != '0);
   assign rsp_held = rsp_valid && rsp_stall;

   // nothing comes out straight after reset
   `TCGS_ASSERT_ALWAYS(a_reset_quiet, reset |=> !rsp_valid, "result valid after reset")

   // a non-empty span blocks new requests through its setup cycles
   `TCGS_ASSERT(a_setup_busy, span_go |=> req_stall ##1 req_stall, "request taken in setup")

   // a held result keeps its value
   `TCGS_ASSERT(a_rsp_hold, rsp_held |=> (rsp_valid && $stable(rsp_data)), "held result changed")

endmodule

bind triangle_color_gradient_span tcgs_checker u_checker (.*);

[tb/sv/tb_triangle_color_gradient_span.sv]
// Self-checking bench for triangle_color_gradient_span: spans go in, shaded pixels
// are predicted in-bench and compared field by field as they leave.
// Depends on tcgs_pkg and the triangle_color_gradient_span RTL.
`timescale 1ns / 1ps

module tb_triangle_color_gradient_span;
   import tcgs_pkg::*;

   localparam longint UV_LIM       = (longint'(1) <<< 46) - 1;
   localparam longint CQ_MAX       = 131071;
   localparam longint CQ_MIN       = -131072;
   localparam int     DRAIN_CYCLES = 80;
   localparam int     RAND_PHASES  = 10;
   localparam int     PHASE_SPANS  = 18;

   typedef enum logic {RX_FREE, RX_PATTERN} rx_mode_type;
   typedef enum logic [1:0] {CFG_NEAR, CFG_WILD, CFG_EDGE} cfg_kind_type;

   logic                 clock        = 1'b0;
   logic                 reset        = 1'b1;
   logic                 req_valid    = 1'b0;
   logic                 req_stall;
   req_type              req_data     = '0;
   logic                 rsp_valid;
   logic                 rsp_stall    = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index    = CSR_INV_ROW_U;
   logic [63:0]          csr_wdata    = '0;

   cfg_type     shade_cfg;
   rsp_type     pixel_q[$];
   int unsigned fail_count   = 0;
   int unsigned pixel_count  = 0;
   int unsigned burst_left   = 0;
   bit          tx_bursty    = 1'b1;
   rx_mode_type rx_mode      = RX_FREE;
   int unsigned hold_request = 0;
   int unsigned hold_left    = 0;
   logic [15:0] stall_pat    = 16'h0a0a;
   logic [3:0]  stall_phase  = '0;
   int          org_x        = 0;
   int          org_y        = 0;

   triangle_color_gradient_span u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_write_en(csr_write_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------- prediction

   function automatic longint clamp(input longint v, input longint lo, input longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   // unit value with fb fraction bits -> 0..255, truncated
   function automatic logic [7:0] to_byte(input longint v, input int fb);
      if (v <= 0) return 8'd0;
      if (v >= (longint'(1) <<< fb)) return 8'd255;
      return 8'((v * 255) >>> fb);
   endfunction

   task automatic shade_span(input req_type r);
      longint su, ku, sv, kv, tu, tv, x2, y2, u2, v2, uc, vc, c, pa;
      longint base[4], du[4], dv[4], q[4];
      int n;
      rsp_type px;
      su = longint'(signed'(shade_cfg.inv_row_u[31:0]));
      ku = longint'(signed'(shade_cfg.inv_row_u[63:32]));
      sv = longint'(signed'(shade_cfg.inv_row_v[31:0]));
      kv = longint'(signed'(shade_cfg.inv_row_v[63:32]));
      tu = longint'(signed'(shade_cfg.inv_offsets[31:0]));
      tv = longint'(signed'(shade_cfg.inv_offsets[63:32]));
      x2 = (longint'(r.span_x) & ((longint'(1) <<< COORD_BITS) - 1)) * 2 + 1;
      y2 = (longint'(r.span_y) & ((longint'(1) <<< COORD_BITS) - 1)) * 2 + 1;
      // u, v carry 17 fraction bits: pixel centre folded in via 2x+1
      u2 = su * x2 + ku * y2 + 2 * tu;
      v2 = sv * x2 + kv * y2 + 2 * tv;
      for (int ch = 0; ch < 4; ch++) begin
         base[ch] = longint'(shade_cfg.base_color[48 - 16 * ch +: 16]);
         du[ch]   = longint'(signed'(shade_cfg.delta_u_color[48 - 16 * ch +: 16]));
         dv[ch]   = longint'(signed'(shade_cfg.delta_v_color[48 - 16 * ch +: 16]));
      end
      n = int'(r.span_length);
      if (n > MAX_SPAN) n = MAX_SPAN;
      for (int k = 0; k < n; k++) begin
         uc = clamp(u2, -UV_LIM, UV_LIM);
         vc = clamp(v2, -UV_LIM, UV_LIM);
         for (int ch = 0; ch < 4; ch++) begin
            c = uc * du[ch] + vc * dv[ch] + (base[ch] <<< 17);
            q[ch] = clamp(c >>> 17, CQ_MIN, CQ_MAX);
         end
         // alpha goes unclamped into the premultiply
         pa = q[0] * longint'(shade_cfg.global_alpha);
         px.alpha_out  = to_byte(pa, 30);
         px.red_out    = to_byte(q[1] * pa, 45);
         px.green_out  = to_byte(q[2] * pa, 45);
         px.blue_out   = to_byte(q[3] * pa, 45);
         px.last_pixel = (k == n - 1);
         pixel_q.push_back(px);
         u2 += 2 * su;
         v2 += 2 * sv;
      end
   endtask

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(input string msg);
      fail_count++;
      if (fail_count <= 40)
         $display("%0t ns: pixel %0d: %s", $time, pixel_count, msg);
   endtask

   task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %h want %h", name, got, want));
   endtask

   always @(posedge clock) begin : pixel_check
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pixel_q.size() == 0) begin
            report_mismatch($sformatf("unexpected pixel %h", rsp_data));
         end else begin
            want = pixel_q.pop_front();
            check_field("alpha", rsp_data.alpha_out, want.alpha_out);
            check_field("red", rsp_data.red_out, want.red_out);
            check_field("green", rsp_data.green_out, want.green_out);
            check_field("blue", rsp_data.blue_out, want.blue_out);
            check_field("last", 8'(rsp_data.last_pixel), 8'(want.last_pixel));
         end
         pixel_count++;
      end
   end

   // ---------------------------------------------------------------- receiver stalls

   always @(posedge clock) begin : rx_stall_gen
      if (hold_request != 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (reset || rx_mode == RX_FREE) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall   <= stall_pat[stall_phase];
         stall_phase <= stall_phase + 1'b1;
         if (stall_phase == 4'hf && $urandom_range(0, 2) == 0) begin
            case ($urandom_range(0, 3))
               0: stall_pat = 16'($urandom & $urandom & $urandom);
               1: stall_pat = 16'($urandom);
               2: stall_pat = 16'($urandom | $urandom);
               default: stall_pat = '0;
            endcase
            stall_pat[0] = 1'b0;  // never a solid stall
         end
      end
   end

   // ---------------------------------------------------------------- drivers

   task automatic offer_span(input req_type r);
      int gap;
      if (tx_bursty) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 10);
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 5);
            if (gap != 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         burst_left--;
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      shade_span(r);
   endtask

   // also covers a trailing zero-length request still in flight
   task automatic wait_pixels_drained();
      req_valid <= 1'b0;
      while (pixel_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_put(input logic [CSR_IDX_W-1:0] idx, input logic [63:0] value);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      @(posedge clock);
   endtask

   task automatic apply_config(input cfg_type c);
      logic [47:0] pad;
      pad = ($urandom_range(0, 1) == 0) ? '0 : 48'({$urandom, $urandom});
      csr_put(CSR_INV_ROW_U, c.inv_row_u);
      csr_put(CSR_INV_ROW_V, c.inv_row_v);
      csr_put(CSR_INV_OFFSETS, c.inv_offsets);
      csr_put(CSR_BASE_COLOR, c.base_color);
      csr_put(CSR_DELTA_U_COLOR, c.delta_u_color);
      csr_put(CSR_DELTA_V_COLOR, c.delta_v_color);
      csr_put(CSR_GLOBAL_ALPHA, {pad, c.global_alpha});
      csr_write_en <= 1'b0;
      shade_cfg = c;
   endtask

   // ---------------------------------------------------------------- generators

   function automatic req_type make_span(input int x, input int y, input int len);
      req_type r;
      r.span_x      = SPAN_X_W'(x);
      r.span_y      = SPAN_X_W'(y);
      r.span_length = SPAN_LEN_W'(len);
      return r;
   endfunction

   function automatic int clip_coord(input int v);
      return (v < 0) ? 0 : ((v > (1 << COORD_BITS) - 1) ? (1 << COORD_BITS) - 1 : v);
   endfunction

   function automatic int rand_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 5) return 0;
      if (pick < 70) return $urandom_range(1, 8);
      if (pick < 88) return $urandom_range(9, 63);
      return $urandom_range(64, 127);
   endfunction

   function automatic req_type near_span(input int len);
      return make_span(clip_coord(org_x + int'($urandom_range(0, 128)) - 64),
                       clip_coord(org_y + int'($urandom_range(0, 64)) - 32), len);
   endfunction

   function automatic logic [63:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [63:0] edge_word();
      case ($urandom_range(0, 6))
         0: return '0;
         1: return '1;
         2: return 64'h7fffffff_7fffffff;
         3: return 64'h80000000_80000000;
         4: return 64'h7fff7fff_7fff7fff;
         5: return 64'h80008000_80008000;
         default: return rand_word();
      endcase
   endfunction

   function automatic logic [15:0] rand_alpha();
      case ($urandom_range(0, 5))
         0: return 16'd0;
         1: return GLOBAL_ALPHA_RESET;
         2: return 16'hffff;
         3: return 16'($urandom);
         default: return 16'($urandom_range(0, 32768));
      endcase
   endfunction

   // coefficients of about 1/32 per pixel, offsets placing u,v near 0..1 at the origin
   function automatic cfg_type near_config();
      cfg_type c;
      int su, ku, sv, kv, tu, tv;
      su = int'($urandom_range(0, 4096)) - 2048;
      ku = int'($urandom_range(0, 4096)) - 2048;
      sv = int'($urandom_range(0, 4096)) - 2048;
      kv = int'($urandom_range(0, 4096)) - 2048;
      tu = -(su * org_x + ku * org_y) + int'($urandom_range(0, 98304)) - 16384;
      tv = -(sv * org_x + kv * org_y) + int'($urandom_range(0, 98304)) - 16384;
      c.inv_row_u   = {32'(ku), 32'(su)};
      c.inv_row_v   = {32'(kv), 32'(sv)};
      c.inv_offsets = {32'(tv), 32'(tu)};
      for (int ch = 0; ch < 4; ch++) begin
         c.base_color[16 * ch +: 16] = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                                   : 16'($urandom_range(0, 36000));
      end
      c.delta_u_color = rand_word();
      c.delta_v_color = rand_word();
      c.global_alpha  = rand_alpha();
      return c;
   endfunction

   function automatic cfg_type rand_config(input cfg_kind_type kind);
      cfg_type c;
      case (kind)
         CFG_NEAR: c = near_config();
         CFG_WILD: begin
            c = {rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
                 rand_word(), 16'($urandom)};
         end
         default: begin
            c = {edge_word(), edge_word(), edge_word(), edge_word(), edge_word(),
                 edge_word(), rand_alpha()};
         end
      endcase
      return c;
   endfunction

   function automatic cfg_type gradient_config(input logic [15:0] alpha);
      cfg_type c;
      c.inv_row_u     = {32'sd16, 32'sd1024};
      c.inv_row_v     = {32'sd256, -32'sd512};
      c.inv_offsets   = {32'sd4096, -32'sd32768};
      c.base_color    = 64'h6000_8000_4000_2000;
      c.delta_u_color = 64'h2000_c000_3000_7fff;
      c.delta_v_color = 64'h1000_2000_8000_0100;
      c.global_alpha  = alpha;
      return c;
   endfunction

   // ---------------------------------------------------------------- tests

   task automatic test_reset_state();
      rx_mode = RX_PATTERN;
      offer_span(make_span(0, 0, 1));
      offer_span(make_span(4095, 4095, 64));
      wait_pixels_drained();
   endtask

   task automatic test_directed_spans();
      apply_config(gradient_config(GLOBAL_ALPHA_RESET));
      offer_span(make_span(0, 0, 1));
      offer_span(make_span(0, 0, 64));
      offer_span(make_span(4095, 0, 64));
      offer_span(make_span(0, 4095, 65));       // clipped to the maximum span
      offer_span(make_span(4095, 4095, 127));
      offer_span(make_span(2047, 2048, 0));     // no pixels at all
      offer_span(make_span(60, 30, 7));
      offer_span(make_span(2048, 2047, 2));
      wait_pixels_drained();
   endtask

   task automatic test_extreme_registers();
      cfg_type set[5];
      set[0] = '1;
      set[1] = {64'h7fffffff_7fffffff, 64'h7fffffff_7fffffff, 64'h7fffffff_7fffffff,
                64'h7fff7fff_7fff7fff, 64'h7fff7fff_7fff7fff, 64'h7fff7fff_7fff7fff, 16'hffff};
      set[2] = {64'h80000000_80000000, 64'h80000000_80000000, 64'h80000000_80000000,
                64'hffff_ffff_ffff_ffff, 64'h8000800080008000, 64'h8000800080008000, 16'd0};
      set[3] = gradient_config(16'hffff);       // opacity above one, used as given
      set[4] = gradient_config(16'd1);
      foreach (set[i]) begin
         apply_config(set[i]);
         offer_span(make_span(0, 0, 3));
         offer_span(make_span(4095, 4095, 64));
         wait_pixels_drained();
      end
   endtask

   // receiver holds off while requests keep coming, so the pipe backs up
   task automatic test_output_backpressure();
      org_x = 1000;
      org_y = 700;
      apply_config(rand_config(CFG_NEAR));
      tx_bursty    = 1'b0;
      hold_request = 400;
      for (int i = 0; i < 16; i++)
         offer_span(near_span($urandom_range(16, 64)));
      wait_pixels_drained();
      tx_bursty = 1'b1;
   endtask

   task automatic test_random_spans();
      int pick;
      for (int phase = 0; phase < RAND_PHASES; phase++) begin
         org_x = $urandom_range(0, 4095);
         org_y = $urandom_range(0, 4095);
         pick  = $urandom_range(0, 8);
         apply_config(rand_config(pick < 6 ? CFG_NEAR : (pick < 8 ? CFG_WILD : CFG_EDGE)));
         tx_bursty = ($urandom_range(0, 3) != 0);
         rx_mode   = ($urandom_range(0, 3) != 0) ? RX_PATTERN : RX_FREE;
         for (int i = 0; i < PHASE_SPANS; i++) begin
            if ($urandom_range(0, 99) < 85)
               offer_span(near_span(rand_length()));
            else
               offer_span(make_span($urandom_range(0, 4095), $urandom_range(0, 4095),
                                    rand_length()));
            if (i == PHASE_SPANS / 2 && phase % 3 == 0)
               wait_pixels_drained();
         end
         wait_pixels_drained();
      end
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      shade_cfg              = '0;
      shade_cfg.global_alpha = GLOBAL_ALPHA_RESET;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_directed_spans();
      test_extreme_registers();
      test_output_backpressure();
      test_random_spans();
      wait_pixels_drained();
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   initial begin
      #12000000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
